// File: sv/tec_pkg.sv
// tec_pkg: widths, command codes and transaction types for the elapsed-time converter
// used by the interfaces and by every module of the converter; no dependencies
`default_nettype none

package tec_pkg;

   localparam int CountW     = 64;
   localparam int FreqW      = 63;
   localparam int CmdW       = 3;
   localparam int SecW       = 55;
   localparam int MsW        = 11;
   localparam int MsRemW     = 10;
   localparam int ScaleW     = 30;
   localparam int PartW      = 62;
   localparam int ProdW      = 93;
   localparam int RawW       = 32;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int QueueLvlW  = 3;

   // seconds split: the magnitude is divided by one thousand a 16-bit chunk at a time
   localparam int MsChunkW   = 16;
   localparam int MsChunks   = 4;
   localparam int MsNumW     = 26;
   localparam int MsRecipW   = 27;
   localparam int MsShift    = 36;
   localparam int MsProdW    = 53;

   localparam logic [ScaleW-1:0]   ScaleNs  = 30'd1000000000;
   localparam logic [ScaleW-1:0]   ScaleUs  = 30'd1000000;
   localparam logic [ScaleW-1:0]   ScaleMs  = 30'd1000;
   localparam logic [MsW-1:0]      MsPerSec = 11'd1000;
   // ceil(2^36 / 1000), exact for every partial dividend below 2^26
   localparam logic [MsRecipW-1:0] MsRecip  = 27'd68719477;

   typedef enum logic [CmdW-1:0] {
      CMD_CYCLES  = 3'd0,
      CMD_NANO    = 3'd1,
      CMD_MICRO   = 3'd2,
      CMD_MILLI32 = 3'd3,
      CMD_MILLI64 = 3'd4,
      CMD_SEC_MS  = 3'd5
   } cmd_type;

   // queue entry: classified command and wrapped tick difference
   typedef struct packed {
      cmd_type             cmd;
      logic [CountW-1:0]   diff;
   } entry_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QueueLvlW-1:0] level;
   } queue_status_type;

   // side data carried alongside the multiply and divide stages
   typedef struct packed {
      cmd_type         cmd;
      logic            neg;
      logic [RawW-1:0] raw;
   } side_type;

   // side data carried alongside the seconds split
   typedef struct packed {
      cmd_type           cmd;
      logic              vneg;
      logic [CountW-1:0] ev;
   } post_type;

   // time-unit scale factor for a command
   function automatic logic [ScaleW-1:0] scale_of(input cmd_type cmd);
      logic [ScaleW-1:0] k;
      case (cmd)
         CMD_NANO:  k = ScaleNs;
         CMD_MICRO: k = ScaleUs;
         default:   k = ScaleMs;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// File: sv/tec_ifs.sv
// request and response channel interfaces of the elapsed-time converter
// depends on tec_pkg for field widths
`default_nettype none

interface tec_req_if;
   import tec_pkg::*;
   logic                valid;
   logic                ready;
   logic [CmdW-1:0]     command;
   logic [CountW-1:0]   start_count;
   logic [CountW-1:0]   stop_count;
   modport source (output valid, command, start_count, stop_count, input ready);
   modport sink   (input valid, command, start_count, stop_count, output ready);
endinterface

interface tec_rsp_if;
   import tec_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [CountW-1:0]  elapsed_value;
   logic signed [SecW-1:0]    whole_seconds;
   logic signed [MsW-1:0]     rest_milliseconds;
   modport source (output valid, elapsed_value, whole_seconds, rest_milliseconds,
                   input ready);
   modport sink   (input valid, elapsed_value, whole_seconds, rest_milliseconds,
                   output ready);
endinterface

`default_nettype wire

// File: sv/timestamp_elapsed_converter.sv
// timestamp_elapsed_converter: top level of the tick-count to time-unit converter
// depends on tec_pkg, tec_ifs, tec_front, tec_queue and tec_back
//
//   channel   direction   handshake        payload
//   req_bus   in          valid / ready    command, start_count, stop_count
//   rsp_bus   out         valid / ready    elapsed_value, whole_seconds, rest_milliseconds
//   csr       in          csr_wr_en        csr_wr_data (counter frequency)
//
// one transaction accepted per cycle while the queue has room; its result passes through
// the 93 one-bit stages of the frequency divider and the 8 stages of the split
// reset (synchronous) empties the queue and the pipeline and sets the frequency to one
// a held result stalls the whole back pipeline; the four-entry queue then fills and
// request ready drops when it is full
`default_nettype none

module timestamp_elapsed_converter (
   input  logic                      clock,
   input  logic                      reset,
   tec_req_if.sink                   req_bus,
   tec_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [tec_pkg::FreqW-1:0] csr_wr_data
);
   import tec_pkg::*;

   logic             freq_ff;
   logic [FreqW-1:0] freq_val_ff;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type q_stat;

   // counter frequency register
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_val_ff <= FreqW'(1);
         freq_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         freq_val_ff <= csr_wr_data;
         freq_ff     <= 1'b1;
      end
   end

   tec_front u_front (
      .req        (req_bus),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   tec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   tec_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .freq   (freq_val_ff),
      .pop    (pop),
      .rsp    (rsp_bus)
   );

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= QueueLvlW'(QueueDepth))
      else $error("queue level beyond depth");

   // a full queue that is not popped stays full
   a_queue_full_push: assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !pop |=> q_stat.full)
      else $error("full queue lost an entry");

   // remainder stays within one second
   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.rest_milliseconds >= -11'sd999) &&
                        (rsp_bus.rest_milliseconds <= 11'sd999))
      else $error("milliseconds remainder out of range");

   // a positive remainder never comes with negative seconds
   a_ms_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.rest_milliseconds > 11'sd0) |->
         (rsp_bus.whole_seconds >= 55'sd0))
      else $error("seconds and remainder signs differ");

   // a frequency write is seen by the back end in the next cycle
   a_freq_load: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> freq_ff && (freq_val_ff == $past(csr_wr_data)))
      else $error("frequency register not loaded");

endmodule

`default_nettype wire

// File: sv/tec_front.sv
// tec_front: accepts request transactions, forms the tick difference and queues it
// depends on tec_pkg and tec_req_if
`default_nettype none

module tec_front (
   tec_req_if.sink                   req,
   input  tec_pkg::queue_status_type q_stat,
   output logic                      push,
   output tec_pkg::entry_type        push_entry
);
   import tec_pkg::*;

   // accept whenever the queue has room
   assign req.ready = !q_stat.full;
   assign push      = req.valid && !q_stat.full;

   // classify and wrap the interval
   always_comb begin
      push_entry.cmd  = cmd_type'(req.command);
      push_entry.diff = req.stop_count - req.start_count;
   end

endmodule

`default_nettype wire

// File: sv/tec_queue.sv
// tec_queue: short queue between the front and the back of the converter
// depends on tec_pkg
`default_nettype none

module tec_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tec_pkg::entry_type        push_entry,
   input  logic                      pop,
   output tec_pkg::entry_type        head,
   output tec_pkg::queue_status_type q_stat
);
   import tec_pkg::*;

   entry_type              slot_ff [0:QueueDepth-1];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueLvlW-1:0]   level_ff, level_in;

   // pointer and level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.level = level_ff;
   assign q_stat.full  = (level_ff == QueueLvlW'(QueueDepth));
   assign q_stat.empty = (level_ff == '0);

endmodule

`default_nettype wire

// File: sv/tec_back.sv
// tec_back: scale, divide by the counter frequency and split into seconds, pipelined
// depends on tec_pkg and tec_rsp_if
`default_nettype none

module tec_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tec_pkg::entry_type        head,
   input  tec_pkg::queue_status_type q_stat,
   input  logic [tec_pkg::FreqW-1:0] freq,
   output logic                      pop,
   tec_rsp_if.source                 rsp
);
   import tec_pkg::*;

   logic             adv;
   logic [FreqW-1:0] dvs;

   // stage a: magnitude and scale
   logic              a_v_ff;
   logic [CountW-1:0] a_mag_ff, a_mag_in;
   logic [ScaleW-1:0] a_k_ff, a_k_in;
   side_type          a_s_ff, a_s_in;

   // stage b: partial products
   logic              b_v_ff;
   logic [PartW-1:0]  b_pl_ff, b_pl_in;
   logic [PartW-1:0]  b_ph_ff, b_ph_in;
   side_type          b_s_ff;

   // frequency divide stages
   logic              d_v_ff [0:ProdW];
   logic [FreqW-1:0]  d_r_ff [0:ProdW];
   logic [ProdW-1:0]  d_w_ff [0:ProdW];
   side_type          d_s_ff [0:ProdW];

   // seconds split stages: partial dividend, chunk shift register and quotient digit
   logic                t_v_ff [0:MsChunks];
   logic [MsNumW-1:0]   t_n_ff [0:MsChunks];
   logic [CountW-1:0]   t_w_ff [0:MsChunks];
   post_type            t_s_ff [0:MsChunks];
   logic                u_v_ff [0:MsChunks-1];
   logic [MsNumW-1:0]   u_n_ff [0:MsChunks-1];
   logic [CountW-1:0]   u_w_ff [0:MsChunks-1];
   logic [MsChunkW-1:0] u_q_ff [0:MsChunks-1];
   post_type            u_s_ff [0:MsChunks-1];

   logic              e_neg;
   logic [CountW-1:0] e_q, e_val, e_ev, e_mag;
   post_type          e_post;

   logic                     rsp_valid_ff;
   logic signed [CountW-1:0] rsp_ev_ff, rsp_ev_in;
   logic signed [SecW-1:0]   rsp_sec_ff, rsp_sec_in;
   logic signed [MsW-1:0]    rsp_ms_ff, rsp_ms_in;

   // whole pipeline moves unless the output register is held
   assign adv = !rsp_valid_ff || rsp.ready;
   assign pop = adv && !q_stat.empty;
   assign dvs = (freq == '0) ? FreqW'(1) : freq;

   // stage a
   always_comb begin
      a_mag_in   = head.diff[CountW-1] ? (CountW'(0) - head.diff) : head.diff;
      a_k_in     = scale_of(head.cmd);
      a_s_in.cmd = head.cmd;
      a_s_in.neg = head.diff[CountW-1];
      a_s_in.raw = head.diff[RawW-1:0];
   end

   // stage b
   always_comb begin
      b_pl_in = PartW'(a_mag_ff[RawW-1:0]) * PartW'(a_k_ff);
      b_ph_in = PartW'(a_mag_ff[CountW-1:RawW]) * PartW'(a_k_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         d_v_ff[0] <= 1'b0;
      end else if (adv) begin
         a_v_ff    <= !q_stat.empty;
         b_v_ff    <= a_v_ff;
         d_v_ff[0] <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff  <= a_mag_in;
         a_k_ff    <= a_k_in;
         a_s_ff    <= a_s_in;
         b_pl_ff   <= b_pl_in;
         b_ph_ff   <= b_ph_in;
         b_s_ff    <= a_s_ff;
         d_r_ff[0] <= '0;
         d_w_ff[0] <= ProdW'(b_pl_ff) + ProdW'({b_ph_ff, 32'b0});
         d_s_ff[0] <= b_s_ff;
      end
   end

   // restoring division by the frequency, one quotient bit per stage
   for (genvar j = 0; j < ProdW; j++) begin : g_div
      logic [FreqW:0]   r2;
      logic             ge;
      logic [FreqW-1:0] r_in;
      logic [ProdW-1:0] w_in;

      always_comb begin
         r2   = {d_r_ff[j], d_w_ff[j][ProdW-1]};
         ge   = (r2 >= {1'b0, dvs});
         r_in = ge ? FreqW'(r2 - {1'b0, dvs}) : r2[FreqW-1:0];
         w_in = {d_w_ff[j][ProdW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            d_v_ff[j+1] <= d_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_r_ff[j+1] <= r_in;
            d_w_ff[j+1] <= w_in;
            d_s_ff[j+1] <= d_s_ff[j];
         end
      end
   end

   // sign, mode select and seconds-split set-up
   always_comb begin
      e_q   = d_w_ff[ProdW][CountW-1:0];
      e_val = d_s_ff[ProdW].neg ? (CountW'(0) - e_q) : e_q;
      case (d_s_ff[ProdW].cmd)
         CMD_CYCLES:                       e_ev = CountW'(d_s_ff[ProdW].raw);
         CMD_NANO, CMD_MICRO, CMD_MILLI32: e_ev = CountW'(e_val[RawW-1:0]);
         CMD_MILLI64, CMD_SEC_MS:          e_ev = e_val;
         default:                          e_ev = '0;
      endcase
      e_neg       = e_val[CountW-1];
      e_mag       = e_neg ? (CountW'(0) - e_val) : e_val;
      e_post.cmd  = d_s_ff[ProdW].cmd;
      e_post.vneg = e_neg;
      e_post.ev   = e_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff[0] <= 1'b0;
      end else if (adv) begin
         t_v_ff[0] <= d_v_ff[ProdW];
      end
   end

   // top chunk starts the long division, the rest wait in the shift register
   always_ff @(posedge clock) begin
      if (adv) begin
         t_n_ff[0] <= MsNumW'(e_mag[CountW-1 -: MsChunkW]);
         t_w_ff[0] <= {e_mag[CountW-MsChunkW-1:0], MsChunkW'(0)};
         t_s_ff[0] <= e_post;
      end
   end

   // division by one thousand, a chunk per two stages by reciprocal multiplication
   for (genvar j = 0; j < MsChunks; j++) begin : g_ms
      logic [MsProdW-1:0] prod;
      logic [MsNumW-1:0]  rem;

      // quotient digit of the partial dividend
      always_comb begin
         prod = MsProdW'(t_n_ff[j]) * MsProdW'(MsRecip);
      end

      // remainder, joined with the next chunk
      always_comb begin
         rem = u_n_ff[j] - MsNumW'(u_q_ff[j]) * MsNumW'(MsPerSec);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            u_v_ff[j]   <= 1'b0;
            t_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            u_v_ff[j]   <= t_v_ff[j];
            t_v_ff[j+1] <= u_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            u_n_ff[j]   <= t_n_ff[j];
            u_w_ff[j]   <= t_w_ff[j];
            u_q_ff[j]   <= prod[MsShift +: MsChunkW];
            u_s_ff[j]   <= t_s_ff[j];
            t_n_ff[j+1] <= {rem[MsRemW-1:0], u_w_ff[j][CountW-1 -: MsChunkW]};
            t_w_ff[j+1] <= {u_w_ff[j][CountW-MsChunkW-1:0], u_q_ff[j]};
            t_s_ff[j+1] <= u_s_ff[j];
         end
      end
   end

   // output fields
   always_comb begin
      rsp_ev_in  = t_s_ff[MsChunks].ev;
      rsp_sec_in = '0;
      rsp_ms_in  = '0;
      if (t_s_ff[MsChunks].cmd == CMD_SEC_MS) begin
         if (t_s_ff[MsChunks].vneg) begin
            rsp_sec_in = SecW'(CountW'(0) - t_w_ff[MsChunks]);
            rsp_ms_in  = MsW'(0) - MsW'(t_n_ff[MsChunks][MsNumW-1 -: MsRemW]);
         end else begin
            rsp_sec_in = SecW'(t_w_ff[MsChunks]);
            rsp_ms_in  = MsW'(t_n_ff[MsChunks][MsNumW-1 -: MsRemW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= t_v_ff[MsChunks];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ev_ff  <= rsp_ev_in;
         rsp_sec_ff <= rsp_sec_in;
         rsp_ms_ff  <= rsp_ms_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.elapsed_value     = rsp_ev_ff;
   assign rsp.whole_seconds     = rsp_sec_ff;
   assign rsp.rest_milliseconds = rsp_ms_ff;

endmodule

`default_nettype wire

// File: verif/tb_tec.sv
// testbench for the elapsed-time converter: directed table then random transactions
// checked against an exact-arithmetic predictor; depends on tec_pkg, tec_ifs and the rtl
`timescale 1ns / 100ps

module testbench;
   import tec_pkg::*;

   localparam int Latency  = 106;
   localparam int MaxCycle = 600000;

   typedef struct {
      logic [CountW-1:0]        ev;
      logic signed [SecW-1:0]   sec;
      logic signed [MsW-1:0]    ms;
   } elapsed_type;

   typedef struct {
      logic [CmdW-1:0]   cmd;
      logic [CountW-1:0] start;
      logic [CountW-1:0] stop;
      logic              typed;
      logic [CountW-1:0] ev;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [FreqW-1:0] csr_wr_data = '0;
   logic [FreqW-1:0] freq_shadow = FreqW'(1);

   tec_req_if req_bus ();
   tec_rsp_if rsp_bus ();

   timestamp_elapsed_converter u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   elapsed_type pending_q[$];
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned sent_count = 0;
   bit rsp_stall_long = 0;

   // exact conversion of one interval
   function automatic elapsed_type convert_interval(logic [CmdW-1:0] cmd,
         logic [CountW-1:0] start, logic [CountW-1:0] stop, logic [FreqW-1:0] freq);
      elapsed_type e;
      logic [CountW-1:0] diff, mag, q, val, vmag, s, r;
      logic [127:0] prod, div;
      logic neg, vneg;
      diff = stop - start;
      neg = diff[63];
      mag = neg ? -diff : diff;
      div = (freq == 0) ? 128'd1 : {65'd0, freq};
      e.ev = '0; e.sec = '0; e.ms = '0;
      if (cmd == CMD_CYCLES) begin
         e.ev = {32'd0, diff[31:0]};
      end else if (cmd <= CMD_SEC_MS) begin
         prod = {64'd0, mag} * ((cmd == CMD_NANO) ? 128'd1000000000 :
                                (cmd == CMD_MICRO) ? 128'd1000000 : 128'd1000);
         q = 64'(prod / div);
         val = neg ? -q : q;
         if (cmd <= CMD_MILLI32) e.ev = {32'd0, val[31:0]};
         else begin
            e.ev = val;
            if (cmd == CMD_SEC_MS) begin
               vneg = val[63];
               vmag = vneg ? -val : val;
               s = vmag / 1000;
               r = vmag % 1000;
               if (vneg) begin
                  s = -s;
                  r = -r;
               end
               e.sec = s[SecW-1:0];
               e.ms = r[MsW-1:0];
            end
         end
      end
      return e;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycle) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response checking at the rising edge
   always @(posedge clock) begin
      elapsed_type x;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_bus.elapsed_value);
         end else begin
            x = pending_q.pop_front();
            if (rsp_bus.elapsed_value !== x.ev || rsp_bus.whole_seconds !== x.sec ||
                rsp_bus.rest_milliseconds !== x.ms) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h %h %h got %h %h %h", x.ev, x.sec, x.ms,
                     rsp_bus.elapsed_value, rsp_bus.whole_seconds, rsp_bus.rest_milliseconds);
            end
         end
      end
   end

   // expectation capture on request acceptance
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         pending_q.push_back(convert_interval(req_bus.command, req_bus.start_count,
            req_bus.stop_count, freq_shadow));
         sent_count++;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
             ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // response ready with random stalls, held high while rsp_stall_long is set
   initial begin
      int g;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         g = rsp_stall_long ? 0 : gap_len();
         if (g > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end else rsp_bus.ready <= 1'b1;
      end
   end

   // one transaction, with a random gap before it when gaps is set
   task automatic send_transaction(logic [CmdW-1:0] cmd, logic [CountW-1:0] a,
         logic [CountW-1:0] b, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.start_count <= a;
      req_bus.stop_count <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_q.size() != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
   endtask

   task automatic write_frequency(logic [FreqW-1:0] f);
      csr_wr_en <= 1'b1;
      csr_wr_data <= f;
      freq_shadow <= f;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CountW-1:0] random_count();
      logic [CountW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: v = '0;
         1: v = '1;
         default: ;
      endcase
      return v;
   endfunction

   row_type table_rows[] = '{
      '{CMD_CYCLES,  64'd0, 64'd0, 1'b1, 64'd0},
      '{CMD_CYCLES,  64'd0, '1, 1'b1, 64'hFFFFFFFF},
      '{CMD_CYCLES,  64'd5, 64'd2, 1'b1, 64'hFFFFFFFD},
      '{CMD_NANO,    64'd0, 64'd1, 1'b1, 64'd1000000000},
      '{CMD_MICRO,   64'd0, 64'd3, 1'b1, 64'd3000000},
      '{CMD_MILLI32, 64'd0, 64'd7, 1'b1, 64'd7000},
      '{CMD_MILLI64, 64'd1, 64'd0, 1'b1, -64'sd1000},
      '{CMD_SEC_MS,  64'd0, 64'd2, 1'b0, 64'd0},
      '{CMD_SEC_MS,  64'd9, 64'd0, 1'b0, 64'd0},
      '{3'd6,        64'd0, 64'd9, 1'b1, 64'd0},
      '{3'd7,        '1,    64'd0, 1'b1, 64'd0},
      '{CMD_NANO,    64'h8000000000000000, 64'd0, 1'b0, 64'd0},
      '{CMD_SEC_MS,  64'h8000000000000000, 64'd0, 1'b0, 64'd0},
      '{CMD_MILLI64, 64'd0, 64'h7FFFFFFFFFFFFFFF, 1'b0, 64'd0},
      '{CMD_SEC_MS,  64'd0, 64'h7FFFFFFFFFFFFFFF, 1'b0, 64'd0}
   };

   logic [FreqW-1:0] freq_set[] = '{63'd0, 63'd1000, 63'h7FFFFFFFFFFFFFFF, 63'd3,
                                    63'd19200000, 63'd1000000000};

   // stimulus
   initial begin
      elapsed_type e;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.start_count = '0;
      req_bus.stop_count = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at reset frequency of one
      foreach (table_rows[i]) begin
         if (table_rows[i].typed) begin
            e = convert_interval(table_rows[i].cmd, table_rows[i].start,
                                 table_rows[i].stop, FreqW'(1));
            if (e.ev !== table_rows[i].ev) begin
               mismatches++;
               $display("table row %0d disagrees with predictor", i);
            end
         end
         send_transaction(table_rows[i].cmd, table_rows[i].start, table_rows[i].stop, 0);
      end
      drain_results();

      // random phases over several frequencies
      foreach (freq_set[p]) begin
         write_frequency(freq_set[p]);
         if (p == 2) rsp_stall_long = 1;
         repeat (130) begin
            logic [CountW-1:0] a;
            a = random_count();
            if ($urandom_range(0, 3) != 0)
               send_transaction(CmdW'($urandom_range(0, 5)), a,
                  a + {{32{1'b0}}, $urandom} * $urandom_range(0, 5000), 1);
            else
               send_transaction(CmdW'($urandom_range(0, 7)), a, random_count(), 1);
         end
         rsp_stall_long = 0;
         drain_results();
      end

      $display("%0d transactions sent, %0d results checked across %0d frequencies",
         sent_count, results_seen, freq_set.size() + 1);
      if (mismatches == 0 && pending_q.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
sv/tec_pkg.sv
sv/tec_ifs.sv
sv/tec_front.sv
sv/tec_queue.sv
sv/tec_back.sv
sv/timestamp_elapsed_converter.sv
verif/tb_tec.sv
